// ===== rtl/core/lfr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LRU frame replacer package
// Request/response types, operation and status codes, control bundles.
// ----------------------------------------------------------------------------
package lfr_pkg;

    localparam int FRAME_W = 4;   // frame_index / victim_frame width
    localparam int TOTAL_W = 5;   // evictable_total width

    // operation codes
    localparam logic [1:0] ACT_ACCESS = 2'd0;
    localparam logic [1:0] ACT_SET    = 2'd1;
    localparam logic [1:0] ACT_EVICT  = 2'd2;
    localparam logic [1:0] ACT_REMOVE = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_UNKNOWN = 2'd1;
    localparam logic [1:0] ST_PINNED  = 2'd2;

    typedef struct packed {
        logic [1:0]         action;
        logic [FRAME_W-1:0] frame_index;
        logic               evictable_flag;
    } t_req;

    typedef struct packed {
        logic               victim_valid;
        logic [FRAME_W-1:0] victim_frame;
        logic [1:0]         status;
        logic [TOTAL_W-1:0] evictable_total;
    } t_rsp;

    // controller -> datapath
    typedef struct packed {
        logic load;     // latch request, restart list walk
        logic scan;     // walk list looking for a match
        logic shift;    // close the gap behind the match
        logic finish;   // commit bit/count updates, load response
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic need_scan;  // request needs a list walk
        logic hit;        // entry on the read port matches
        logic walk_end;   // no read pending, none left to issue
    } t_sts;

endpackage : lfr_pkg
`default_nettype wire

// ===== rtl/core/lfr_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LRU frame replacer controller
// Sequences check, list walk, gap close and response strobe.
// ----------------------------------------------------------------------------
module lfr_ctrl
    import lfr_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic start,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd,
    output logic      busy,
    output logic      o_rsp_valid
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_SHIFT = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_sts.need_scan) begin
                    n_state = S_SCAN;
                end else begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_DONE;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.hit) begin
                    n_state = S_SHIFT;
                end else if (i_sts.walk_end) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_DONE;
                end
            end
            S_SHIFT: begin
                o_cmd.shift = 1'b1;
                if (i_sts.walk_end) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_DONE;
                end
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy        = (r_state != S_IDLE);
    assign o_rsp_valid = (r_state == S_DONE);

endmodule : lfr_ctrl
`default_nettype wire

// ===== rtl/core/lfr_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LRU frame replacer datapath
// Recency list memory, present/evictable bits, counters, response register.
// ----------------------------------------------------------------------------
module lfr_datapath
    import lfr_pkg::*;
#(
    parameter int FRAME_SLOTS = 16
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_req i_req,
    input  wire t_cmd i_cmd,
    output t_sts      o_sts,
    output t_rsp      o_rsp
);

    localparam int IW = $clog2(FRAME_SLOTS);
    localparam int CW = $clog2(FRAME_SLOTS + 1);

    // recency list, least recent at address 0
    logic [FRAME_W-1:0] mem [FRAME_SLOTS];

    t_req                   r_req;
    logic [FRAME_SLOTS-1:0] r_present;
    logic [FRAME_SLOTS-1:0] r_evb;
    logic [CW-1:0]          r_len;
    logic [CW-1:0]          r_cnt;
    logic [CW-1:0]          r_rd_ptr;
    logic                   r_rd_v;
    logic [IW-1:0]          r_rd_addr;
    logic [FRAME_W-1:0]     r_rd_data;
    logic                   r_found;
    logic [FRAME_W-1:0]     r_hit_frame;
    t_rsp                   r_rsp;

    logic [FRAME_SLOTS-1:0] n_present;
    logic [FRAME_SLOTS-1:0] n_evb;
    logic [CW-1:0]          n_len;
    logic [CW-1:0]          n_cnt;
    t_rsp                   n_rsp;

    logic [FRAME_W+IW-1:0] f_ext;
    logic [FRAME_W+IW-1:0] d_ext;
    logic [FRAME_W+IW-1:0] h_ext;
    logic [CW+TOTAL_W-1:0] cnt_ext;
    logic [IW-1:0]         f_idx;
    logic [IW-1:0]         d_idx;
    logic [IW-1:0]         h_idx;
    logic                  f_ok;
    logic                  present_f;
    logic                  evb_f;
    logic                  rd_en;
    logic                  hit;
    logic [CW-1:0]         len_m1;
    logic                  wr_en;
    logic [IW-1:0]         wr_addr;
    logic [FRAME_W-1:0]    wr_data;

    // frame numbers into bit-array indexes
    assign f_ext     = {{IW{1'b0}}, r_req.frame_index};
    assign d_ext     = {{IW{1'b0}}, r_rd_data};
    assign h_ext     = {{IW{1'b0}}, r_hit_frame};
    assign f_idx     = f_ext[IW-1:0];
    assign d_idx     = d_ext[IW-1:0];
    assign h_idx     = h_ext[IW-1:0];
    assign f_ok      = (f_ext < (FRAME_W+IW)'(FRAME_SLOTS));
    assign present_f = f_ok && r_present[f_idx];
    assign evb_f     = f_ok && r_evb[f_idx];
    assign len_m1    = r_len - 1'b1;

    assign rd_en = (i_cmd.scan || i_cmd.shift) && (r_rd_ptr < r_len);
    assign hit   = r_rd_v && ((r_req.action == ACT_EVICT) ? r_evb[d_idx]
                                                          : (r_rd_data == r_req.frame_index));

    always_comb begin
        case (r_req.action)
            ACT_ACCESS: o_sts.need_scan = present_f;
            ACT_EVICT:  o_sts.need_scan = (r_cnt != '0);
            ACT_REMOVE: o_sts.need_scan = present_f && evb_f;
            default:    o_sts.need_scan = 1'b0;
        endcase
        o_sts.hit      = hit;
        o_sts.walk_end = !r_rd_v && !(r_rd_ptr < r_len);
    end

    // single write port: gap close, or append at finish
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_rd_addr - 1'b1;
        wr_data = r_rd_data;
        if (i_cmd.shift && r_rd_v) begin
            wr_en = 1'b1;
        end else if (i_cmd.finish && (r_req.action == ACT_ACCESS) && f_ok) begin
            wr_data = r_req.frame_index;
            if (present_f) begin
                wr_en   = r_found;
                wr_addr = len_m1[IW-1:0];
            end else begin
                wr_en   = 1'b1;
                wr_addr = r_len[IW-1:0];
            end
        end
    end

    // commit values for the finish step
    always_comb begin
        n_present = r_present;
        n_evb     = r_evb;
        n_len     = r_len;
        n_cnt     = r_cnt;
        n_rsp     = '0;
        n_rsp.status = ST_OK;
        case (r_req.action)
            ACT_ACCESS: begin
                if (f_ok && !present_f) begin
                    n_present[f_idx] = 1'b1;
                    n_evb[f_idx]     = 1'b0;
                    n_len            = r_len + 1'b1;
                end
            end
            ACT_SET: begin
                if (!present_f) begin
                    n_rsp.status = ST_UNKNOWN;
                end else if (evb_f != r_req.evictable_flag) begin
                    n_evb[f_idx] = r_req.evictable_flag;
                    if (r_req.evictable_flag) begin
                        n_cnt = r_cnt + 1'b1;
                    end else if (r_cnt != '0) begin
                        n_cnt = r_cnt - 1'b1;
                    end
                end
            end
            ACT_EVICT: begin
                if (r_found) begin
                    n_rsp.victim_valid = 1'b1;
                    n_rsp.victim_frame = r_hit_frame;
                    n_present[h_idx]   = 1'b0;
                    n_evb[h_idx]       = 1'b0;
                    n_len              = len_m1;
                    if (r_cnt != '0) begin
                        n_cnt = r_cnt - 1'b1;
                    end
                end
            end
            ACT_REMOVE: begin
                if (present_f && !evb_f) begin
                    n_rsp.status = ST_PINNED;
                end else if (present_f && r_found) begin
                    n_present[f_idx] = 1'b0;
                    n_evb[f_idx]     = 1'b0;
                    n_len            = len_m1;
                    if (r_cnt != '0) begin
                        n_cnt = r_cnt - 1'b1;
                    end
                end
            end
            default: begin
                n_rsp.status = ST_OK;
            end
        endcase
        cnt_ext               = {{TOTAL_W{1'b0}}, n_cnt};
        n_rsp.evictable_total = cnt_ext[TOTAL_W-1:0];
    end

    // memory ports
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= mem[r_rd_ptr[IW-1:0]];
            r_rd_addr <= r_rd_ptr[IW-1:0];
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_req;
        end
        if (i_cmd.scan && hit) begin
            r_hit_frame <= r_rd_data;
        end
        if (i_cmd.finish) begin
            r_rsp <= n_rsp;
        end
    end

    // control and bookkeeping state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_present <= '0;
            r_evb     <= '0;
            r_len     <= '0;
            r_cnt     <= '0;
            r_rd_ptr  <= '0;
            r_rd_v    <= 1'b0;
            r_found   <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_rd_ptr <= '0;
                r_rd_v   <= 1'b0;
                r_found  <= 1'b0;
            end else if (i_cmd.scan || i_cmd.shift) begin
                r_rd_v <= rd_en;
                if (rd_en) begin
                    r_rd_ptr <= r_rd_ptr + 1'b1;
                end
            end
            if (i_cmd.scan && hit) begin
                r_found <= 1'b1;
            end
            if (i_cmd.finish) begin
                r_present <= n_present;
                r_evb     <= n_evb;
                r_len     <= n_len;
                r_cnt     <= n_cnt;
            end
        end
    end

    assign o_rsp = r_rsp;

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    a_len_matches_present: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_present) == int'(r_len))
        else $error("list length differs from present frame count");

    a_cnt_matches_evb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_evb) == int'(r_cnt))
        else $error("evictable count differs from evictable bits");

    a_evb_subset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_evb & ~r_present) == '0)
        else $error("evictable bit set on absent frame");

    a_walk_ends_in_list: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rd_en |=> (r_rd_ptr <= r_len))
        else $error("list walk ran past the list end");

endmodule : lfr_datapath
`default_nettype wire

// ===== rtl/core/lru_frame_replacer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LRU frame replacer with pinning
// Keeps frames in recency order with present/evictable flags; services
// access, set-evictable, evict and remove requests one at a time.
// ----------------------------------------------------------------------------
//  Channel    Signals                      Direction  Handshake
//  request    start, i_req                 in         accepted when start && !busy
//  response   o_rsp_valid, o_rsp           out        one-cycle strobe, never stalls
//
//  Flow: set, pinned/absent remove, new-frame access and an evict with
//  nothing evictable go from the check straight to the strobe. Access of
//  a present frame, evict and remove walk the list, at most FRAME_SLOTS
//  entries, one entry a cycle through its single read port. busy drops
//  the cycle after the strobe.
//  Reset: synchronous, active low; empties the list and clears all flags
//  and counts. No clearing pass: unused list entries are never read.
//  The receiver cannot stall: a response is valid for exactly one cycle.
// ----------------------------------------------------------------------------
module lru_frame_replacer
    import lfr_pkg::*;
#(
    parameter int FRAME_SLOTS = 16   // frame capacity, 2..16
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic start,
    input  wire t_req i_req,
    output logic      busy,
    output logic      o_rsp_valid,
    output t_rsp      o_rsp
);

    // command/status bundles between controller and datapath
    t_cmd cmd;
    t_sts sts;

    // controller: check -> walk (find match) -> close gap -> strobe
    lfr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .busy        (busy),
        .o_rsp_valid (o_rsp_valid)
    );

    // datapath: list memory, flag arrays, counters, response register
    lfr_datapath #(
        .FRAME_SLOTS (FRAME_SLOTS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .o_rsp   (o_rsp)
    );

endmodule : lru_frame_replacer
`default_nettype wire
